// ----- src/qsed_pkg.sv -----
// Shared types and constants for the quoted string escape decoder.
// Used by every module under src; the channel interfaces do not use it.

package qsed_pkg;

	// Default depth of the queue between the decoder and the output stage.
	localparam int FifoDepth = 4;

	// Result kinds.
	localparam logic [1:0] KindByte  = 2'd0;
	localparam logic [1:0] KindClose = 2'd1;
	localparam logic [1:0] KindErr   = 2'd2;

	// Error codes.
	localparam logic [1:0] ErrNone = 2'd0;
	localparam logic [1:0] ErrEnd  = 2'd1;
	localparam logic [1:0] ErrEol  = 2'd2;
	localparam logic [1:0] ErrEsc  = 2'd3;

	// Pending line break after an escaped break.
	localparam logic [1:0] BrkNone = 2'd0;
	localparam logic [1:0] BrkLf   = 2'd1;
	localparam logic [1:0] BrkCr   = 2'd2;

	// Characters.
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChDquote = 8'h22;
	localparam logic [7:0] ChSquote = 8'h27;
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChSpace  = 8'h20;

	// Hex letters carry nine more than their low nibble.
	localparam logic [7:0] HexLetterAdj = 8'd9;

	typedef enum logic [7:0] {
		ModeWait  = 8'b0000_0001,
		ModeBody  = 8'b0000_0010,
		ModeEsc   = 8'b0000_0100,
		ModeHex1  = 8'b0000_1000,
		ModeHex2  = 8'b0001_0000,
		ModeDec   = 8'b0010_0000,
		ModeBreak = 8'b0100_0000,
		ModeZskip = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] err;
	} result_t;

	// One queue entry holds all results caused by one input item.
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- src/qsed_if.sv -----
// Channel interfaces of the quoted string escape decoder.
// Depends on nothing; payload widths are fixed by the item fields.

interface qsed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       at_end;

	modport source (output valid, in_byte, at_end, input ready);
	modport sink (input valid, in_byte, at_end, output ready);
endinterface

interface qsed_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [1:0] err_code;

	modport source (output valid, out_kind, out_byte, err_code, input ready);
	modport sink (input valid, out_kind, out_byte, err_code, output ready);
endinterface

// ----- src/quoted_string_escape_decoder_unit.sv -----
// Top level of the quoted string escape decoder.
// Uses qsed_pkg, qsed_if, qsed_front, qsed_fifo and qsed_back.
//
// The chars channel takes one source byte per item (in_byte, with at_end
// marking end of input). Bytes before an opening quote are dropped. Inside
// a string each decoded byte comes out on the results channel as a byte
// item; the matching closing quote gives a close item and a fault gives an
// error item with err_code. One source byte causes zero, one or two results.
// Throughput is one source byte per cycle while the result queue is not full;
// the escape state machine in the front end decodes each byte as it is
// accepted. The output register sends one result per cycle while the
// receiver is ready, so the two results of one byte leave one after the other.
// The first result of an accepted byte is written into the queue at the
// accepting edge and moves on into the output register once that register
// is empty or its item is taken.
// When the receiver stalls, results collect in the queue (FifoDepth entries)
// and chars.ready drops once it is full; the output item holds steady.
// Reset clears the decoder to waiting for a quote and empties the queue and
// the output register; no result is valid after reset.

module quoted_string_escape_decoder_unit #(
	parameter int FifoDepth = qsed_pkg::FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	qsed_in_if.sink     chars,
	qsed_out_if.source  results
);

	qsed_pkg::fifo_stat_t stat;
	qsed_pkg::entry_t     wdata, head;
	logic                 push, pop;

	qsed_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.stat   (stat),
		.push   (push),
		.entry  (wdata)
	);

	qsed_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	qsed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.pop     (pop),
		.results (results)
	);

`ifndef SYNTH
	// The front end never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("result queue overflow");

	// An error item always carries a cause; other items never do.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> ((results.out_kind == qsed_pkg::KindErr) ==
			(results.err_code != qsed_pkg::ErrNone)))
		else $error("error code does not match result kind");

	// Close and error items never carry a data byte.
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.out_kind != qsed_pkg::KindByte) |->
			(results.out_byte == 8'd0))
		else $error("close or error item with nonzero byte");
`endif

endmodule

// ----- src/qsed_front.sv -----
// Front end: accepts source bytes, runs the escape state machine and
// packs the results of each byte into one queue entry. Uses qsed_pkg, qsed_if.

module qsed_front (
	input  logic                clk,
	input  logic                arst_n,
	qsed_in_if.sink             chars,
	input  qsed_pkg::fifo_stat_t stat,
	output logic                push,
	output qsed_pkg::entry_t    entry
);

	typedef struct packed {
		qsed_pkg::mode_t   mode;
		logic              clr;
		logic              emit;
		qsed_pkg::result_t res;
	} body_t;

	qsed_pkg::mode_t mode_q, mode_d;
	logic            cq_q, cq_d;
	logic [9:0]      ev_q, ev_d;
	logic [1:0]      dc_q, dc_d;
	logic [1:0]      pb_q, pb_d;

	logic              accept;
	logic [1:0]        cnt;
	qsed_pkg::result_t r0, r1;
	body_t             bb;
	logic              use_body;
	logic [7:0]        c;
	logic              fin;
	logic              dig, xlet;
	logic [9:0]        dec_nv;
	logic [7:0]        hex_sum;
	logic [7:0]        brk_other;

	function automatic body_t body_step(input logic [7:0] ch, input logic e, input logic q);
		body_t      b;
		logic [7:0] delim;
		delim  = q ? qsed_pkg::ChSquote : qsed_pkg::ChDquote;
		b.mode = qsed_pkg::ModeBody;
		b.clr  = 1'b0;
		b.emit = 1'b1;
		b.res  = '{kind: qsed_pkg::KindByte, data: ch, err: qsed_pkg::ErrNone};
		if (e) begin
			b.clr = 1'b1;
			b.res = '{kind: qsed_pkg::KindErr, data: 8'd0, err: qsed_pkg::ErrEnd};
		end else if (ch == delim) begin
			b.clr = 1'b1;
			b.res = '{kind: qsed_pkg::KindClose, data: 8'd0, err: qsed_pkg::ErrNone};
		end else if (ch == qsed_pkg::ChLf || ch == qsed_pkg::ChCr) begin
			b.clr = 1'b1;
			b.res = '{kind: qsed_pkg::KindErr, data: 8'd0, err: qsed_pkg::ErrEol};
		end else if (ch == qsed_pkg::ChBslash) begin
			b.mode = qsed_pkg::ModeEsc;
			b.emit = 1'b0;
		end
		if (b.clr) begin
			b.mode = qsed_pkg::ModeWait;
		end
		return b;
	endfunction

	assign c      = chars.in_byte;
	assign fin    = chars.at_end;
	assign dig    = (c >= qsed_pkg::ChZero) && (c <= 8'h39);
	assign xlet   = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	assign bb     = body_step(c, fin, cq_q);
	assign dec_nv = {ev_q[6:0], 3'b000} + {ev_q[8:0], 1'b0} + {6'd0, c[3:0]};
	assign hex_sum = ev_q[7:0] + {4'd0, c[3:0]} + (xlet ? qsed_pkg::HexLetterAdj : 8'd0);
	assign brk_other = (pb_q == qsed_pkg::BrkLf) ? qsed_pkg::ChCr : qsed_pkg::ChLf;

	assign chars.ready = !stat.full;
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		mode_d   = mode_q;
		cq_d     = cq_q;
		ev_d     = ev_q;
		dc_d     = dc_q;
		pb_d     = pb_q;
		cnt      = 2'd0;
		r0       = '0;
		r1       = '0;
		use_body = 1'b0;
		unique case (mode_q) inside
			qsed_pkg::ModeBody: begin
				use_body = 1'b1;
			end
			qsed_pkg::ModeEsc: begin
				mode_d = qsed_pkg::ModeBody;
				cnt    = 2'd1;
				r0     = '{kind: qsed_pkg::KindByte, data: c, err: qsed_pkg::ErrNone};
				if (fin) begin
					r0 = '{kind: qsed_pkg::KindErr, data: 8'd0, err: qsed_pkg::ErrEnd};
				end else begin
					unique case (c) inside
						"a": r0.data = 8'd7;
						"b": r0.data = 8'd8;
						"f": r0.data = 8'd12;
						"n": r0.data = 8'd10;
						"r": r0.data = 8'd13;
						"t": r0.data = 8'd9;
						"v": r0.data = 8'd11;
						qsed_pkg::ChBslash, qsed_pkg::ChDquote, qsed_pkg::ChSquote: r0.data = c;
						"x": begin
							mode_d = qsed_pkg::ModeHex1;
							ev_d   = 10'd0;
							cnt    = 2'd0;
						end
						"z": begin
							mode_d = qsed_pkg::ModeZskip;
							cnt    = 2'd0;
						end
						qsed_pkg::ChLf, qsed_pkg::ChCr: begin
							mode_d  = qsed_pkg::ModeBreak;
							pb_d    = (c == qsed_pkg::ChLf) ? qsed_pkg::BrkLf : qsed_pkg::BrkCr;
							r0.data = qsed_pkg::ChLf;
						end
						default: begin
							if (dig) begin
								mode_d = qsed_pkg::ModeDec;
								ev_d   = {6'd0, c[3:0]};
								dc_d   = 2'd1;
								cnt    = 2'd0;
							end else begin
								r0 = '{kind: qsed_pkg::KindErr, data: 8'd0,
									err: qsed_pkg::ErrEsc};
							end
						end
					endcase
				end
				if (cnt != 2'd0 && r0.kind == qsed_pkg::KindErr) begin
					mode_d = qsed_pkg::ModeWait;
					cq_d   = 1'b0;
					ev_d   = 10'd0;
					dc_d   = 2'd0;
					pb_d   = qsed_pkg::BrkNone;
				end
			end
			qsed_pkg::ModeHex1, qsed_pkg::ModeHex2: begin
				if (fin || !(dig || xlet)) begin
					mode_d = qsed_pkg::ModeWait;
					cq_d   = 1'b0;
					ev_d   = 10'd0;
					dc_d   = 2'd0;
					pb_d   = qsed_pkg::BrkNone;
					cnt    = 2'd1;
					r0     = '{kind: qsed_pkg::KindErr, data: 8'd0, err: qsed_pkg::ErrEsc};
				end else if (mode_q == qsed_pkg::ModeHex1) begin
					ev_d   = {2'd0, c[3:0] + (xlet ? 4'd9 : 4'd0), 4'd0};
					mode_d = qsed_pkg::ModeHex2;
				end else begin
					ev_d   = 10'd0;
					mode_d = qsed_pkg::ModeBody;
					cnt    = 2'd1;
					r0     = '{kind: qsed_pkg::KindByte, data: hex_sum, err: qsed_pkg::ErrNone};
				end
			end
			qsed_pkg::ModeDec: begin
				if (!fin && dig) begin
					if (dc_q < 2'd2) begin
						ev_d = dec_nv;
						dc_d = 2'd2;
					end else if (dec_nv > 10'd255) begin
						mode_d = qsed_pkg::ModeWait;
						cq_d   = 1'b0;
						ev_d   = 10'd0;
						dc_d   = 2'd0;
						pb_d   = qsed_pkg::BrkNone;
						cnt    = 2'd1;
						r0     = '{kind: qsed_pkg::KindErr, data: 8'd0, err: qsed_pkg::ErrEsc};
					end else begin
						ev_d   = 10'd0;
						dc_d   = 2'd0;
						mode_d = qsed_pkg::ModeBody;
						cnt    = 2'd1;
						r0     = '{kind: qsed_pkg::KindByte, data: dec_nv[7:0],
							err: qsed_pkg::ErrNone};
					end
				end else begin
					// The finished value goes out first; the byte is then body text.
					ev_d     = 10'd0;
					dc_d     = 2'd0;
					cnt      = 2'd1;
					r0       = '{kind: qsed_pkg::KindByte, data: ev_q[7:0],
						err: qsed_pkg::ErrNone};
					use_body = 1'b1;
				end
			end
			qsed_pkg::ModeBreak: begin
				pb_d = qsed_pkg::BrkNone;
				if (!fin && c == brk_other) begin
					mode_d = qsed_pkg::ModeBody;
				end else begin
					use_body = 1'b1;
				end
			end
			qsed_pkg::ModeZskip: begin
				if (fin || !(c == qsed_pkg::ChSpace || (c >= 8'd9 && c <= 8'd13))) begin
					use_body = 1'b1;
				end
			end
			default: begin
				mode_d = qsed_pkg::ModeWait;
				cq_d   = 1'b0;
				ev_d   = 10'd0;
				dc_d   = 2'd0;
				pb_d   = qsed_pkg::BrkNone;
				if (!fin && (c == qsed_pkg::ChDquote || c == qsed_pkg::ChSquote)) begin
					cq_d   = (c == qsed_pkg::ChSquote);
					mode_d = qsed_pkg::ModeBody;
				end
			end
		endcase
		if (use_body) begin
			mode_d = bb.mode;
			if (bb.clr) begin
				cq_d = 1'b0;
				ev_d = 10'd0;
				dc_d = 2'd0;
				pb_d = qsed_pkg::BrkNone;
			end
			if (bb.emit) begin
				if (cnt == 2'd0) begin
					r0 = bb.res;
				end else begin
					r1 = bb.res;
				end
				cnt = cnt + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= qsed_pkg::ModeWait;
			cq_q   <= 1'b0;
			ev_q   <= 10'd0;
			dc_q   <= 2'd0;
			pb_q   <= qsed_pkg::BrkNone;
		end else if (accept) begin
			mode_q <= mode_d;
			cq_q   <= cq_d;
			ev_q   <= ev_d;
			dc_q   <= dc_d;
			pb_q   <= pb_d;
		end
	end

	assign push  = accept && (cnt != 2'd0);
	assign entry = '{r0: r0, r1: r1, two: (cnt == 2'd2)};

endmodule

// ----- src/qsed_fifo.sv -----
// Short queue of result entries between the front end and the output stage.
// Uses qsed_pkg for the entry and status types.

module qsed_fifo #(
	parameter int Depth = qsed_pkg::FifoDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  qsed_pkg::entry_t     wdata,
	input  logic                 pop,
	output qsed_pkg::entry_t     head,
	output qsed_pkg::fifo_stat_t stat
);

	// Depth must be at least two.
	localparam int AW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	qsed_pkg::entry_t mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == CW'(Depth));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/qsed_back.sv -----
// Output stage: takes queue entries and hands their results out one at a
// time through an output register. Uses qsed_pkg and qsed_if.

module qsed_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qsed_pkg::entry_t     head,
	input  qsed_pkg::fifo_stat_t stat,
	output logic                 pop,
	qsed_out_if.source           results
);

	logic              valid_q;
	logic              half_q;
	qsed_pkg::result_t res_q;
	logic              load, take;

	assign load = !valid_q || results.ready;
	assign take = load && !stat.empty;
	// An entry leaves the queue once its last result is loaded.
	assign pop  = take && (half_q || !head.two);

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= half_q ? head.r1 : head.r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= take;
			if (take) begin
				half_q <= !half_q && head.two;
			end
		end
	end

	assign results.valid    = valid_q;
	assign results.out_kind = res_q.kind;
	assign results.out_byte = res_q.data;
	assign results.err_code = res_q.err;

endmodule
